// ===== hw/rtl/button_click_and_hold_classifier_assert.svh =====
// Assertion helpers for the classifier RTL.
`ifndef BUTTON_CLICK_AND_HOLD_CLASSIFIER_ASSERT_SVH
`define BUTTON_CLICK_AND_HOLD_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define BCHC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define BCHC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/bchc_pkg.sv =====
package bchc_pkg;

	// Configuration register indexes.
	localparam logic [2:0] RegGlitch     = 3'd0;
	localparam logic [2:0] RegShortTo    = 3'd1;
	localparam logic [2:0] RegLongMin    = 3'd2;
	localparam logic [2:0] RegLongCount  = 3'd3;
	localparam logic [2:0] RegThresh0    = 3'd4;

	// Event codes.
	localparam logic [1:0] EvBurst  = 2'd0;
	localparam logic [1:0] EvMedium = 2'd1;
	localparam logic [1:0] EvLong   = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [15:0] GlitchReset  = 16'd50;
	localparam logic [15:0] ShortToReset = 16'd300;
	localparam logic [15:0] LongMinReset = 16'd1000;

	localparam int LongLevelsDefault = 4;
	localparam int ThreshRegs        = 4;
	localparam int FifoDepth         = 4;
	localparam int FifoAw            = 2;

	typedef struct packed {
		logic [1:0]  event_code;
		logic [7:0]  click_count;
		logic [1:0]  long_level;
		logic [15:0] hold_ms;
		logic        last;
	} result_t;

endpackage

// ===== hw/rtl/button_click_and_hold_classifier.sv =====
// A beat accepted on s_* is held in the input register until the result queue has room,
// then processed, and its results are written to the result queue that drives m_*.
// Throughput: one input beat per cycle while each tick gives at most one result and m_tready
// keeps the queue drained; a tick with two results needs two output beats, and the input
// stalls while the result queue holds more than two beats.
// Reset (arst_n low, asynchronous): queue empty, configuration at its
// defaults, all tracking state cleared to zero.
`include "button_click_and_hold_classifier_assert.svh"

module button_click_and_hold_classifier
	import bchc_pkg::*;
#(
	parameter int LONG_LEVELS = LongLevelsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // pin_level, now_ms, zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // event_code, click_count, long_level, hold_ms, zero fill
	output logic        m_tlast
);

	localparam int NLev = (LONG_LEVELS < ThreshRegs) ? LONG_LEVELS : ThreshRegs;

	// Configuration.
	logic [15:0] glitch_q, short_to_q, long_min_q;
	logic [2:0]  long_count_q;
	logic [15:0] thresh_q [NLev];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glitch_q     <= GlitchReset;
			short_to_q   <= ShortToReset;
			long_min_q   <= LongMinReset;
			long_count_q <= 3'd0;
			for (int i = 0; i < NLev; i++) thresh_q[i] <= 16'd0;
		end else if (cfg_we) begin
			if (cfg_index == RegGlitch) glitch_q <= cfg_data;
			if (cfg_index == RegShortTo) short_to_q <= cfg_data;
			if (cfg_index == RegLongMin) long_min_q <= cfg_data;
			if (cfg_index == RegLongCount) long_count_q <= cfg_data[2:0];
			for (int i = 0; i < NLev; i++) begin
				if (cfg_index == 3'(int'(RegThresh0) + i)) thresh_q[i] <= cfg_data;
			end
		end
	end

	// Input register.
	logic        vld_s1;
	logic        pin_s1;
	logic [31:0] now_s1;
	logic        proc;
	logic        in_acc;

	assign in_acc   = s_tvalid && s_tready;
	assign s_tready = !vld_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_acc) begin
			vld_s1 <= 1'b1;
		end else if (proc) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pin_s1 <= s_tdata[0];
			now_s1 <= s_tdata[32:1];
		end
	end

	// Tracking state.
	logic        is_pressed_q;
	logic [31:0] edge_time_q, prev_press_q, burst_start_q;
	logic [7:0]  clicks_q;
	logic        burst_armed_q;

	// Result queue.
	result_t            fifo_q [FifoDepth];
	logic [FifoAw-1:0]  wr_ptr_q, rd_ptr_q;
	logic [FifoAw:0]    cnt_q;
	logic               pop;

	assign proc     = vld_s1 && (cnt_q <= (FifoAw+1)'(FifoDepth - 2));
	assign m_tvalid = (cnt_q != '0);
	assign pop      = m_tvalid && m_tready;

	// Per-tick decision.
	logic [31:0] since, hold, gap, burst_age;
	logic        expire, press_ok, release_ok, is_click;
	logic        long_found;
	logic [1:0]  long_lvl;
	logic [7:0]  clicks_base, clicks_next;
	logic [15:0] hold_sat;
	logic        edge_res_v;
	result_t     burst_res, edge_res, push0, push1;
	logic        push0_v, push1_v;
	logic        burst_push;

	always_comb begin
		since      = now_s1 - edge_time_q;
		hold       = since;
		gap        = edge_time_q - prev_press_q;
		burst_age  = now_s1 - burst_start_q;
		expire     = burst_armed_q && (burst_age >= {16'd0, short_to_q});
		press_ok   = !pin_s1 && !is_pressed_q && (since > {16'd0, glitch_q});
		release_ok = pin_s1 && is_pressed_q && (since > {16'd0, glitch_q});
		is_click   = hold < {16'd0, short_to_q};
		hold_sat   = (hold[31:16] != 16'd0) ? 16'hFFFF : hold[15:0];

		// The highest-indexed enabled threshold at or below the hold wins.
		long_found = 1'b0;
		long_lvl   = 2'd0;
		for (int i = 0; i < NLev; i++) begin
			if (3'(i) < long_count_q && hold >= {16'd0, thresh_q[i]}) begin
				long_found = 1'b1;
				long_lvl   = 2'(i);
			end
		end

		clicks_base = (clicks_q == 8'd0) ? 8'd1 : clicks_q;
		if (!is_click) begin
			clicks_next = 8'd1;
		end else if (gap < {16'd0, short_to_q}) begin
			clicks_next = (clicks_base == 8'hFF) ? clicks_base : clicks_base + 8'd1;
		end else begin
			clicks_next = 8'd1;
		end

		burst_res = '{event_code: EvBurst, click_count: clicks_q, long_level: 2'd0,
			hold_ms: 16'd0, last: 1'b0};
		if (hold < {16'd0, long_min_q}) begin
			edge_res = '{event_code: EvMedium, click_count: 8'd0, long_level: 2'd0,
				hold_ms: hold_sat, last: 1'b1};
			edge_res_v = release_ok && !is_click;
		end else begin
			edge_res = '{event_code: EvLong, click_count: 8'd0, long_level: long_lvl,
				hold_ms: hold_sat, last: 1'b1};
			edge_res_v = release_ok && !is_click && long_found;
		end

		push0_v = proc && (expire || edge_res_v);
		push1_v = proc && expire && edge_res_v;
		push0   = expire ? burst_res : edge_res;
		push0.last = !push1_v;
		push1   = edge_res;
	end

	assign burst_push = push0_v && push0.event_code == EvBurst;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_pressed_q  <= 1'b0;
			edge_time_q   <= 32'd0;
			prev_press_q  <= 32'd0;
			clicks_q      <= 8'd0;
			burst_armed_q <= 1'b0;
			burst_start_q <= 32'd0;
		end else if (proc) begin
			if (press_ok) begin
				is_pressed_q <= 1'b1;
				edge_time_q  <= now_s1;
			end else if (release_ok) begin
				is_pressed_q <= 1'b0;
				clicks_q     <= clicks_next;
				prev_press_q <= edge_time_q;
				edge_time_q  <= now_s1;
				if (is_click) burst_start_q <= now_s1;
			end
			// A click re-arms the timer even when it runs out on the same tick.
			if (release_ok && is_click) begin
				burst_armed_q <= 1'b1;
			end else if (expire) begin
				burst_armed_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FifoAw'(push0_v) + FifoAw'(push1_v);
			rd_ptr_q <= rd_ptr_q + FifoAw'(pop);
			cnt_q    <= cnt_q + (FifoAw+1)'(push0_v) + (FifoAw+1)'(push1_v)
				- (FifoAw+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push0_v) fifo_q[wr_ptr_q] <= push0;
		if (push1_v) fifo_q[wr_ptr_q + FifoAw'(1)] <= push1;
	end

	result_t head;
	assign head    = fifo_q[rd_ptr_q];
	assign m_tdata = {4'd0, head.hold_ms, head.long_level, head.click_count, head.event_code};
	assign m_tlast = head.last;

	`BCHC_ASSERT_NOW(a_queue_bound, 1'b1, cnt_q <= (FifoAw+1)'(FifoDepth), "queue overflow")
	`BCHC_ASSERT_NOW(a_stall_only_busy, !s_tready, vld_s1 && !proc, "stall without held tick")
	`BCHC_ASSERT_NOW(a_burst_needs_arm, burst_push, burst_armed_q, "burst with timer idle")
	`BCHC_ASSERT_NEXT(a_release_clears, proc && release_ok, !is_pressed_q, "press state kept")
	`BCHC_ASSERT_NEXT(a_click_arms, proc && release_ok && is_click, burst_armed_q, "timer idle")

endmodule
